// ===== design/chwd_pkg.sv =====
// ----------------------------------------------------------------------------
// Compass heading package
// Shared types, widths, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package chwd_pkg;

   // CORDIC and fixed point set-up
   localparam int CORDIC_STEPS    = 16;
   localparam int ANGLE_FRAC_BITS = 8;
   localparam int ACC_FRAC        = 20;
   localparam int IN_SCALE        = 14;

   localparam int FIELD_W   = 16;
   localparam int MODE_W    = 2;
   localparam int HEADING_W = 9;
   localparam int DECL_W    = 17;
   localparam int THRESH_W  = 9;
   localparam int PERIOD_W  = 16;
   localparam int COUNT_W   = 16;

   // Datapath widths: vector components carry the CORDIC gain and the
   // diagonal growth, the angle accumulator holds up to 512 degrees either way.
   localparam int XY_W  = FIELD_W + IN_SCALE + 4;
   localparam int Z_W   = ACC_FRAC + 10;
   localparam int SUM_W = ANGLE_FRAC_BITS + 12;
   localparam int DEC_W = DECL_W + ANGLE_FRAC_BITS;

   localparam logic signed [Z_W-1:0]   Z_QUARTER = Z_W'(90 * (2 ** ACC_FRAC));
   localparam logic signed [SUM_W-1:0] FULL_TURN = SUM_W'(360 * (2 ** ANGLE_FRAC_BITS));
   localparam logic [HEADING_W-1:0]    HEADING_LIMIT = HEADING_W'(360);
   localparam logic [COUNT_W-1:0]      COUNT_MAX = '1;

   // Result queue between the front and back end
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = DECL_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECLINATION = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD      = 2'd2;

   localparam logic signed [DECL_W-1:0] DECL_RESET   = DECL_W'(1468);
   localparam logic [THRESH_W-1:0]      THRESH_RESET = THRESH_W'(4);
   localparam logic [PERIOD_W-1:0]      PERIOD_RESET = PERIOD_W'(500);

   // Sample modes; the fourth code behaves as count only.
   localparam logic [MODE_W-1:0] MODE_NORMAL      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FORCE_RESET = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COUNT_ONLY  = 2'd2;

   typedef struct packed {
      logic signed [FIELD_W-1:0] field_x;
      logic signed [FIELD_W-1:0] field_y;
      logic [MODE_W-1:0]         mode;
   } req_type;

   typedef struct packed {
      logic [HEADING_W-1:0] heading_deg;
      logic                 report_valid;
      logic                 sensor_reset_request;
   } rsp_type;

   // Word passed from the front end to the back end through the queue
   typedef struct packed {
      logic [HEADING_W-1:0] heading_deg;
      logic [MODE_W-1:0]    mode;
   } chwd_item_type;

   // atan(2^-i) in degrees with ACC_FRAC fraction bits
   function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] step);
      logic signed [Z_W-1:0] value;
      case (step)
         5'd0:    value = Z_W'(47185920);
         5'd1:    value = Z_W'(27855475);
         5'd2:    value = Z_W'(14718068);
         5'd3:    value = Z_W'(7471121);
         5'd4:    value = Z_W'(3750058);
         5'd5:    value = Z_W'(1876857);
         5'd6:    value = Z_W'(938658);
         5'd7:    value = Z_W'(469357);
         5'd8:    value = Z_W'(234682);
         5'd9:    value = Z_W'(117342);
         5'd10:   value = Z_W'(58671);
         5'd11:   value = Z_W'(29335);
         5'd12:   value = Z_W'(14668);
         5'd13:   value = Z_W'(7334);
         5'd14:   value = Z_W'(3667);
         5'd15:   value = Z_W'(1833);
         5'd16:   value = Z_W'(917);
         5'd17:   value = Z_W'(458);
         5'd18:   value = Z_W'(229);
         5'd19:   value = Z_W'(115);
         5'd20:   value = Z_W'(57);
         5'd21:   value = Z_W'(29);
         5'd22:   value = Z_W'(14);
         5'd23:   value = Z_W'(7);
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

// ===== design/chwd_front.sv =====
// ----------------------------------------------------------------------------
// Compass heading front end
// Pipelined CORDIC in vectoring mode, one iteration per stage, followed by
// the declination add and the wrap into whole degrees.
// ----------------------------------------------------------------------------
module chwd_front import chwd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   input  logic signed [DECL_W-1:0] declination,
   input  logic                     q_full,
   output logic                     q_push,
   output chwd_item_type            q_item
);

   logic signed [XY_W-1:0] in_x, in_y;
   logic                   in_zero;

   logic [CORDIC_STEPS:0]  valid_ff, valid_in;
   logic signed [XY_W-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [XY_W-1:0] x_in [0:CORDIC_STEPS];
   logic signed [XY_W-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [XY_W-1:0] y_in [0:CORDIC_STEPS];
   logic signed [Z_W-1:0]  z_ff [0:CORDIC_STEPS];
   logic signed [Z_W-1:0]  z_in [0:CORDIC_STEPS];
   logic [MODE_W-1:0]      mode_ff [0:CORDIC_STEPS];
   logic [MODE_W-1:0]      mode_in [0:CORDIC_STEPS];
   logic [CORDIC_STEPS:0]  zero_ff, zero_in;

   logic signed [Z_W-1:0]   ang_wide;
   logic signed [SUM_W-1:0] ang;
   logic signed [DEC_W-1:0] dec_wide;
   logic signed [SUM_W-1:0] dec;

   logic                    sum_valid_ff, sum_valid_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [MODE_W-1:0]       sum_mode_ff, sum_mode_in;

   logic signed [SUM_W-1:0] wrap_a, wrap_b, wrap_c, wrap_d;
   logic                    head_valid_ff, head_valid_in;
   chwd_item_type           head_ff, head_in;

   logic advance;

   // The whole pipeline moves together; it holds only when the last word
   // cannot enter the queue.
   assign advance   = !(head_valid_ff && q_full);
   assign req_ready = advance;
   assign q_push    = head_valid_ff && !q_full;
   assign q_item    = head_ff;

   // Scale the sample and turn the left half-plane into the right one.
   always_comb begin
      in_x = {{(XY_W-FIELD_W-IN_SCALE){req_data.field_x[FIELD_W-1]}},
              req_data.field_x, {IN_SCALE{1'b0}}};
      in_y = {{(XY_W-FIELD_W-IN_SCALE){req_data.field_y[FIELD_W-1]}},
              req_data.field_y, {IN_SCALE{1'b0}}};
      in_zero = (req_data.field_x == '0) && (req_data.field_y == '0);

      valid_in[0] = req_valid;
      zero_in[0]  = in_zero;
      mode_in[0]  = req_data.mode;
      x_in[0]     = in_x;
      y_in[0]     = in_y;
      z_in[0]     = '0;
      if (in_x[XY_W-1]) begin
         if (!in_y[XY_W-1]) begin
            x_in[0] = in_y;
            y_in[0] = -in_x;
            z_in[0] = Z_QUARTER;
         end else begin
            x_in[0] = -in_y;
            y_in[0] = in_x;
            z_in[0] = -Z_QUARTER;
         end
      end

      for (int k = 0; k < CORDIC_STEPS; k++) begin
         valid_in[k+1] = valid_ff[k];
         zero_in[k+1]  = zero_ff[k];
         mode_in[k+1]  = mode_ff[k];
         if (!y_ff[k][XY_W-1]) begin
            x_in[k+1] = x_ff[k] + (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] - (x_ff[k] >>> k);
            z_in[k+1] = z_ff[k] + atan_entry(5'(k));
         end else begin
            x_in[k+1] = x_ff[k] - (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] + (x_ff[k] >>> k);
            z_in[k+1] = z_ff[k] - atan_entry(5'(k));
         end
      end
   end

   // Angle floored to the heading format, declination brought to it too.
   always_comb begin
      ang_wide = z_ff[CORDIC_STEPS] >>> (ACC_FRAC - ANGLE_FRAC_BITS);
      ang      = ang_wide[SUM_W-1:0];
      dec_wide = ($signed({{ANGLE_FRAC_BITS{declination[DECL_W-1]}}, declination})
                  <<< ANGLE_FRAC_BITS) >>> 8;
      dec      = dec_wide[SUM_W-1:0];

      sum_valid_in = valid_ff[CORDIC_STEPS];
      sum_mode_in  = mode_ff[CORDIC_STEPS];
      // A zero vector has no direction; its angle counts as zero, so it reads as the declination.
      sum_in       = zero_ff[CORDIC_STEPS] ? dec : ang + dec;
   end

   // Two corrections each way cover every sum of angle and declination.
   always_comb begin
      wrap_a = (sum_ff < 0) ? sum_ff + FULL_TURN : sum_ff;
      wrap_b = (wrap_a < 0) ? wrap_a + FULL_TURN : wrap_a;
      wrap_c = (wrap_b >= FULL_TURN) ? wrap_b - FULL_TURN : wrap_b;
      wrap_d = (wrap_c >= FULL_TURN) ? wrap_c - FULL_TURN : wrap_c;

      head_valid_in       = sum_valid_ff;
      head_in.heading_deg = wrap_d[ANGLE_FRAC_BITS +: HEADING_W];
      head_in.mode        = sum_mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         sum_valid_ff  <= 1'b0;
         head_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff      <= valid_in;
         sum_valid_ff  <= sum_valid_in;
         head_valid_ff <= head_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff        <= x_in;
         y_ff        <= y_in;
         z_ff        <= z_in;
         mode_ff     <= mode_in;
         zero_ff     <= zero_in;
         sum_ff      <= sum_in;
         sum_mode_ff <= sum_mode_in;
         head_ff     <= head_in;
      end
   end

endmodule

// ===== design/chwd_queue.sv =====
// ----------------------------------------------------------------------------
// Compass heading queue
// Short first-in first-out buffer between the front and back end.
// ----------------------------------------------------------------------------
module chwd_queue import chwd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  chwd_item_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          pop_valid,
   output chwd_item_type pop_item
);

   chwd_item_type    mem_ff [0:FIFO_DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign full      = (count_ff == (PTR_W+1)'(FIFO_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   // The front end must hold its word while the queue is full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("word pushed into a full queue");

   // The back end only takes a word that is there.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("word popped from an empty queue");

endmodule

// ===== design/chwd_back.sv =====
// ----------------------------------------------------------------------------
// Compass heading back end
// Deadband report against the last reported heading, the sensor reset
// counter and the output register.
// ----------------------------------------------------------------------------
module chwd_back import chwd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  chwd_item_type       q_item,
   output logic                q_pop,
   input  logic [THRESH_W-1:0] threshold,
   input  logic [PERIOD_W-1:0] period,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data
);

   logic [COUNT_W-1:0]   counter_ff, counter_in;
   logic [HEADING_W-1:0] last_ff, last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic [HEADING_W-1:0] diff;
   logic                 report;
   logic                 request;

   assign q_pop     = q_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      counter_in = counter_ff;
      request    = 1'b0;
      if (q_item.mode == MODE_NORMAL && counter_ff > period) begin
         request    = 1'b1;
         counter_in = '0;
      end else if (q_item.mode == MODE_FORCE_RESET) begin
         request = 1'b1;
      end else if (counter_ff != COUNT_MAX) begin
         counter_in = counter_ff + 1'b1;
      end

      diff    = (q_item.heading_deg >= last_ff) ? q_item.heading_deg - last_ff
                                                : last_ff - q_item.heading_deg;
      report  = (diff > threshold);
      last_in = report ? q_item.heading_deg : last_ff;

      rsp_in.heading_deg          = q_item.heading_deg;
      rsp_in.report_valid         = report;
      rsp_in.sensor_reset_request = request;

      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            counter_ff <= counter_in;
            last_ff    <= last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.heading_deg < HEADING_LIMIT)
      else $error("heading outside a full turn");

   a_forced_request: assert property (@(posedge clock) disable iff (reset)
      q_pop && q_item.mode == MODE_FORCE_RESET
      |=> rsp_ff.sensor_reset_request && counter_ff == $past(counter_ff))
      else $error("forced sensor reset not requested or counter moved");

   a_report_updates_last: assert property (@(posedge clock) disable iff (reset)
      q_pop && report |=> rsp_ff.report_valid && last_ff == rsp_ff.heading_deg)
      else $error("reported heading not kept as the last report");

endmodule

// ===== design/compass_heading_with_deadband_report.sv =====
// Path: an accepted word passes the CORDIC stages, the sum and heading registers
// and the queue to the output register; it waits while the output stalls.
// Throughput: one word per cycle unless the output stalls; each CORDIC iteration
// is its own pipeline stage; the back end settles deadband and counter per word.
// Reset is synchronous: it empties the pipeline and queue, clears the counter
// and last report, and restores the register defaults.
// ----------------------------------------------------------------------------
// Compass heading with deadband report
// Top level: configuration registers, CORDIC front end, queue and back end.
// ----------------------------------------------------------------------------
module compass_heading_with_deadband_report import chwd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic signed [DECL_W-1:0] decl_ff, decl_in;
   logic [THRESH_W-1:0]      thresh_ff, thresh_in;
   logic [PERIOD_W-1:0]      period_ff, period_in;

   logic          q_push;
   logic          q_full;
   chwd_item_type q_push_item;
   logic          q_pop;
   logic          q_valid;
   chwd_item_type q_pop_item;

   always_comb begin
      decl_in   = decl_ff;
      thresh_in = thresh_ff;
      period_in = period_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DECLINATION: decl_in   = csr_write_data[DECL_W-1:0];
            CSR_THRESHOLD:   thresh_in = csr_write_data[THRESH_W-1:0];
            CSR_PERIOD:      period_in = csr_write_data[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decl_ff   <= DECL_RESET;
         thresh_ff <= THRESH_RESET;
         period_ff <= PERIOD_RESET;
      end else begin
         decl_ff   <= decl_in;
         thresh_ff <= thresh_in;
         period_ff <= period_in;
      end
   end

   chwd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .declination (decl_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (q_push_item)
   );

   chwd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (q_pop_item)
   );

   chwd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_pop_item),
      .q_pop     (q_pop),
      .threshold (thresh_ff),
      .period    (period_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
